// ===== hdl/kdg_pkg.sv =====
// ----------------------------------------------------------------------------
// Per-site discrete Gaussian generator: shared package
// Types for the item, result and command payloads, generator constants and
// the map from a 3-bit code to a deviate level.
// ----------------------------------------------------------------------------
package kdg_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned LEVEL_W = 15;
  localparam int unsigned DEV_W   = 16;
  localparam int unsigned SITE_W  = 10;
  localparam int unsigned PADDR_W = 3;

  localparam logic [WORD_W-1:0] LCG_MUL  = 32'd69069;
  localparam logic [WORD_W-1:0] LCG_ADD  = 32'd1234567;
  localparam logic [WORD_W-1:0] MWC_Z_MUL = 32'd36969;
  localparam logic [WORD_W-1:0] MWC_W_MUL = 32'd18000;

  localparam logic [LEVEL_W-1:0] OUTER_RESET = 15'd15137;
  localparam logic [LEVEL_W-1:0] INNER_RESET = 15'd6270;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DRAW  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_DRAW  = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    REG_OUTER = 1'b0,
    REG_INNER = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MULT,
    ST_MIX,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SITE_W-1:0] site;
    logic [WORD_W-1:0] seed_a;
    logic [WORD_W-1:0] seed_b;
    logic [WORD_W-1:0] seed_c;
    logic [WORD_W-1:0] seed_d;
  } item_t;

  typedef struct packed {
    logic signed [DEV_W-1:0] deviate;
    logic [WORD_W-1:0]       state_word;
    logic                    last;
  } result_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic                site_ok;
    logic [SITE_W-1:0]   site;
    logic [4*WORD_W-1:0] seeds;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] outer;
    logic [LEVEL_W-1:0] inner;
  } levels_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } back_status_t;

  function automatic logic [DEV_W-1:0] code_level(input logic [2:0] code,
                                                 input levels_t   lv);
    logic [DEV_W-1:0] outer_w;
    logic [DEV_W-1:0] inner_w;
    logic [DEV_W-1:0] res;
    outer_w = {1'b0, lv.outer};
    inner_w = {1'b0, lv.inner};
    unique case (code)
      3'd0:    res = DEV_W'(0) - outer_w;
      3'd1:    res = DEV_W'(0) - inner_w;
      3'd6:    res = inner_w;
      3'd7:    res = outer_w;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== hdl/kdg_front.sv =====
// ----------------------------------------------------------------------------
// Front end: item intake and command queue
// Accepts items, classifies them into commands and holds them in a two-entry
// queue for the back end. Unused opcodes and writes to absent sites are dropped.
// ----------------------------------------------------------------------------
module kdg_front #(
  parameter int unsigned NSITES = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  kdg_pkg::item_t item,
  input  logic           clearing,
  output logic           cmd_valid,
  input  logic           cmd_pop,
  output kdg_pkg::cmd_t  cmd
);

  kdg_pkg::cmd_t q [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  kdg_pkg::cmd_t cls;
  logic          keep;
  logic          push;
  logic [16:0]   site_ext;

  always_comb begin
    site_ext    = {7'd0, item.site};
    cls.site    = item.site;
    cls.seeds   = {item.seed_a, item.seed_b, item.seed_c, item.seed_d};
    cls.site_ok = site_ext < 17'(NSITES);
    cls.kind    = kdg_pkg::CMD_DRAW;
    keep        = 1'b0;
    unique case (kdg_pkg::opcode_t'(item.opcode))
      kdg_pkg::OP_WRITE: begin
        cls.kind = kdg_pkg::CMD_WRITE;
        keep     = cls.site_ok;
      end
      kdg_pkg::OP_READ: begin
        cls.kind = kdg_pkg::CMD_READ;
        keep     = 1'b1;
      end
      kdg_pkg::OP_DRAW: begin
        cls.kind = kdg_pkg::CMD_DRAW;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign item_stall = (count == 2'd2) || clearing;
  assign push       = item_valid && !item_stall && keep;
  assign cmd_valid  = (count != 2'd0);
  assign cmd        = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

// ===== hdl/kdg_back.sv =====
// ----------------------------------------------------------------------------
// Back end: state store, generator step and result output
// Holds the per-site generator words in one memory and runs one command at a
// time: a write goes straight to memory, a read through the fetch step, a draw
// through fetch, multiply and mix steps; results leave through an output register.
// ----------------------------------------------------------------------------
module kdg_back #(
  parameter int unsigned NSITES            = 1024,
  parameter int unsigned DEVIATES_PER_DRAW = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kdg_pkg::levels_t      levels,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  input  kdg_pkg::cmd_t         cmd,
  output kdg_pkg::back_status_t status,
  output logic                  result_valid,
  input  logic                  result_stall,
  output kdg_pkg::result_t      result
);

  localparam int unsigned ADDR_W = (NSITES > 1) ? $clog2(NSITES) : 1;
  localparam int unsigned CNT_MAX = (DEVIATES_PER_DRAW > 4) ? DEVIATES_PER_DRAW : 4;
  localparam int unsigned CNT_W  = $clog2(CNT_MAX);
  localparam int unsigned W      = kdg_pkg::WORD_W;

  kdg_pkg::back_state_t state;
  kdg_pkg::back_state_t state_next;

  logic [4*W-1:0]  mem [NSITES];
  logic [4*W-1:0]  rdata;
  logic [ADDR_W-1:0] clr_addr;

  kdg_pkg::cmd_kind_t cur_kind;
  logic               cur_ok;
  logic [ADDR_W-1:0]  cur_addr;

  logic [W-1:0] wd [4];
  logic [W-1:0] nx;
  logic [W-1:0] ny;
  logic [W-1:0] nz;
  logic [W-1:0] nw;
  logic [W-3:0] code_bits;
  logic [CNT_W-1:0] cnt;

  logic [16:0]       cmd_site_ext;
  logic [ADDR_W-1:0] cmd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [4*W-1:0]    mem_wdata;
  logic              emit_go;
  logic              last_now;
  logic [W-1:0]      y1;
  logic [W-1:0]      y2;
  logic [W-1:0]      mixed;

  assign cmd_site_ext = {7'd0, cmd.site};
  assign cmd_addr     = cmd_site_ext[ADDR_W-1:0];

  // A read emits the four words, a draw emits one deviate per 3-bit code.
  assign last_now = (cur_kind == kdg_pkg::CMD_READ) ? (cnt == CNT_W'(3))
                                                    : (cnt == CNT_W'(DEVIATES_PER_DRAW - 1));
  assign emit_go  = (state == kdg_pkg::ST_EMIT) && (!result_valid || !result_stall);

  assign y1    = wd[1] ^ (wd[1] << 17);
  assign y2    = y1 ^ (y1 >> 13);
  assign mixed = ny + (nx ^ ((nz << 16) + nw));

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = cur_addr;
    mem_wdata  = {nx, ny, nz, nw};
    unique case (state)
      kdg_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
        if (clr_addr == ADDR_W'(NSITES - 1)) begin
          state_next = kdg_pkg::ST_IDLE;
        end
      end
      kdg_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.kind == kdg_pkg::CMD_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = cmd_addr;
            mem_wdata = cmd.seeds;
          end else begin
            state_next = kdg_pkg::ST_FETCH;
          end
        end
      end
      kdg_pkg::ST_FETCH: begin
        state_next = (cur_kind == kdg_pkg::CMD_READ) ? kdg_pkg::ST_EMIT : kdg_pkg::ST_MULT;
      end
      kdg_pkg::ST_MULT: begin
        state_next = kdg_pkg::ST_MIX;
      end
      kdg_pkg::ST_MIX: begin
        mem_we     = cur_ok;
        state_next = kdg_pkg::ST_EMIT;
      end
      kdg_pkg::ST_EMIT: begin
        if (emit_go && last_now) begin
          state_next = kdg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kdg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kdg_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == kdg_pkg::ST_CLEAR) begin
      clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[cmd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_kind <= cmd.kind;
      cur_ok   <= cmd.site_ok;
      cur_addr <= cmd_addr;
    end
    // An absent site behaves as an all-zero state that is never stored.
    if (state == kdg_pkg::ST_FETCH) begin
      wd[0] <= cur_ok ? rdata[4*W-1:3*W] : '0;
      wd[1] <= cur_ok ? rdata[3*W-1:2*W] : '0;
      wd[2] <= cur_ok ? rdata[2*W-1:W]   : '0;
      wd[3] <= cur_ok ? rdata[W-1:0]     : '0;
    end
    if (state == kdg_pkg::ST_MULT) begin
      nx <= wd[0] * kdg_pkg::LCG_MUL + kdg_pkg::LCG_ADD;
      ny <= y2 ^ (y2 << 5);
      nz <= W'(wd[2][15:0]) * kdg_pkg::MWC_Z_MUL + (wd[2] >> 16);
      nw <= W'(wd[3][15:0]) * kdg_pkg::MWC_W_MUL + (wd[3] >> 16);
    end
    if (state == kdg_pkg::ST_MIX) begin
      code_bits <= mixed[W-1:2];
    end else if (emit_go) begin
      code_bits <= code_bits >> 3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state != kdg_pkg::ST_EMIT) begin
      cnt <= '0;
    end else if (emit_go) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      result.last <= last_now;
      if (cur_kind == kdg_pkg::CMD_READ) begin
        result.deviate    <= '0;
        result.state_word <= wd[cnt[1:0]];
      end else begin
        result.deviate    <= kdg_pkg::code_level(code_bits[2:0], levels);
        result.state_word <= '0;
      end
    end
  end

  assign status.clearing = (state == kdg_pkg::ST_CLEAR);
  assign status.busy     = (state != kdg_pkg::ST_IDLE) && (state != kdg_pkg::ST_CLEAR);

endmodule

// ===== hdl/per_site_kiss_discrete_gaussian.sv =====
// Flow: a write goes from the queue straight into the site store. A read passes the
// fetch state before its first word, and a draw passes the fetch, multiply and mix
// states before its first deviate. Throughput: one command at a time in the back end, at
// one result per cycle while result_stall is low; the queue takes two items ahead.
// Reset: a clearing pass zeroes every entry of the site store; item_stall is high
// throughout, and configuration writes are taken as ever.
// ----------------------------------------------------------------------------
// Per-site discrete Gaussian generator: top level
// Level registers on the APB port, the front end with its command queue and
// the back end with the site store, generator step and output register.
// ----------------------------------------------------------------------------
module per_site_kiss_discrete_gaussian #(
  parameter int unsigned NSITES            = 1024,
  parameter int unsigned DEVIATES_PER_DRAW = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  kdg_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output kdg_pkg::result_t              result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kdg_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  kdg_pkg::levels_t      levels;
  kdg_pkg::back_status_t status;
  kdg_pkg::cmd_t         cmd;
  logic                  cmd_valid;
  logic                  cmd_pop;
  logic                  cfg_write;
  kdg_pkg::reg_index_t   reg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel   = kdg_pkg::reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      levels.outer <= kdg_pkg::OUTER_RESET;
      levels.inner <= kdg_pkg::INNER_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        kdg_pkg::REG_OUTER: levels.outer <= pwdata[kdg_pkg::LEVEL_W-1:0];
        kdg_pkg::REG_INNER: levels.inner <= pwdata[kdg_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      kdg_pkg::REG_OUTER: prdata = {17'd0, levels.outer};
      kdg_pkg::REG_INNER: prdata = {17'd0, levels.inner};
      default:            prdata = '0;
    endcase
  end

  kdg_front #(
    .NSITES (NSITES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .clearing   (status.clearing),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .cmd        (cmd)
  );

  kdg_back #(
    .NSITES            (NSITES),
    .DEVIATES_PER_DRAW (DEVIATES_PER_DRAW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .levels       (levels),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  // The store is swept clean before any item gets in.
  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> item_stall)
    else $error("item accepted during clearing pass");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (rst)
    status.clearing |-> !result_valid)
    else $error("result shown during clearing pass");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> status.clearing)
    else $error("clearing pass did not start after reset");

  // The back end takes a new command only when it is idle.
  a_pop_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (cmd_valid && !status.busy && !status.clearing))
    else $error("command taken while the back end was busy");
`endif

endmodule
